[rtl/core/cdq_pkg.sv]
// Shared types and constants for the circular deque core.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_NOP        = 3'd4
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [WORD_W-1:0] data;
    } t_slot_wr;

    typedef struct packed {
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
    } t_pair;

endpackage

[rtl/core/circular_deque_core.sv]
// Top level of the circular deque: command decode, pointers and the row of slot cells.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Word
// in        sink       i_in_valid / o_in_ready   i_cmd, i_value
// out       source     o_out_valid / i_out_ready o_ok, o_front_value, o_rear_value,
//                                                o_is_empty, o_is_full
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_data (capacity)
//
// Each command's result waits on the gather chain that walks the front and rear
// words through all DEPTH slot cells, one cell per cycle. One command is in
// flight at a time.
// The next command is accepted as soon as the previous result has moved into
// the output register, even while that word still waits on i_out_ready.
// Reset clears pointers, count and handshake state and sets capacity to 64;
// slot contents are not cleared.

module circular_deque_core #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_cmd,
    input  logic signed [cdq_pkg::WORD_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ok,
    output logic signed [cdq_pkg::WORD_W-1:0] o_front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] o_rear_value,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]         i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;

    logic [cdq_pkg::CAP_W-1:0] r_cap;
    logic [AW-1:0]             r_front, n_front;
    logic [AW-1:0]             r_rear, n_rear;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_busy;
    logic [CW-1:0]             r_sweep;
    logic                      r_p_ok, r_p_empty, r_p_full;
    logic                      n_ok;
    logic                      r_out_valid;
    logic                      r_ok, r_empty, r_full;
    logic [cdq_pkg::WORD_W-1:0] r_front_val, r_rear_val;

    logic [EW-1:0]             w_cap_eff;
    logic                      w_full_now, w_empty_now;
    logic                      w_in_acc, w_sweep_done, w_load;
    logic [AW-1:0]             w_wr_addr;
    cdq_pkg::t_slot_wr         w_wr;
    cdq_pkg::t_pair            w_gather [DEPTH];

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx,
                                              input logic [EW-1:0] cap);
        logic [EW-1:0] sum;
        sum = EW'(idx) + EW'(1);
        step_up = (sum >= cap) ? '0 : sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx,
                                                input logic [EW-1:0] cap);
        logic [EW-1:0] last;
        last = cap - EW'(1);
        step_down = (idx == '0) ? last[AW-1:0] : idx - AW'(1);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = EW'(1);
        end else if (EW'(r_cap) > EW'(DEPTH)) begin
            w_cap_eff = EW'(DEPTH);
        end else begin
            w_cap_eff = EW'(r_cap);
        end
    end

    assign w_full_now  = EW'(r_count) >= w_cap_eff;
    assign w_empty_now = r_count == '0;

    always_comb begin
        n_front   = r_front;
        n_rear    = r_rear;
        n_count   = r_count;
        n_ok      = 1'b0;
        w_wr_addr = '0;
        w_wr.we   = 1'b0;
        w_wr.data = i_value;
        case (i_cmd)
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
                if (!w_full_now) begin
                    if (w_empty_now) begin
                        n_front   = '0;
                        n_rear    = '0;
                        w_wr_addr = '0;
                    end else if (i_cmd == cdq_pkg::CMD_PUSH_FRONT) begin
                        n_front   = step_down(r_front, w_cap_eff);
                        w_wr_addr = n_front;
                    end else begin
                        n_rear    = step_up(r_rear, w_cap_eff);
                        w_wr_addr = n_rear;
                    end
                    n_count = r_count + CW'(1);
                    w_wr.we = w_in_acc;
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT: begin
                if (!w_empty_now) begin
                    n_front = step_up(r_front, w_cap_eff);
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_REAR: begin
                if (!w_empty_now) begin
                    n_rear  = step_down(r_rear, w_cap_eff);
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::CMD_NOP: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cdq_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
        end else if (w_in_acc) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p_ok    <= n_ok;
            r_p_empty <= n_count == '0;
            r_p_full  <= EW'(n_count) >= w_cap_eff;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cdq_pkg::t_pair w_prev;
            if (g == 0) begin : g_head
                assign w_prev = '0;
            end else begin : g_link
                assign w_prev = w_gather[g-1];
            end
            cdq_cell #(
                .AW  (AW),
                .IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_wr        (w_wr),
                .i_wr_addr   (w_wr_addr),
                .i_front_ptr (r_front),
                .i_rear_ptr  (r_rear),
                .i_prev      (w_prev),
                .o_gather    (w_gather[g])
            );
        end
    endgenerate

    assign w_sweep_done = r_sweep == CW'(DEPTH);
    assign w_load       = r_busy && w_sweep_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_sweep <= '0;
        end else if (w_in_acc) begin
            r_busy  <= 1'b1;
            r_sweep <= '0;
        end else if (w_load) begin
            r_busy <= 1'b0;
        end else if (r_busy && !w_sweep_done) begin
            r_sweep <= r_sweep + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ok        <= r_p_ok;
            r_empty     <= r_p_empty;
            r_full      <= r_p_full;
            r_front_val <= r_p_empty ? cdq_pkg::EMPTY_WORD : w_gather[DEPTH-1].front;
            r_rear_val  <= r_p_empty ? cdq_pkg::EMPTY_WORD : w_gather[DEPTH-1].rear;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;
    assign o_front_value = r_front_val;
    assign o_rear_value  = r_rear_val;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the slot count.");

    a_accept_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_busy && (r_sweep == '0)))
        else $error("Accepted command did not start a gather sweep.");

    a_result_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && w_sweep_done))
        else $error("Result word issued before the gather sweep finished.");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |->
            ((r_front_val == cdq_pkg::EMPTY_WORD) && (r_rear_val == cdq_pkg::EMPTY_WORD)))
        else $error("Empty deque result carries data words.");

endmodule

[rtl/core/cdq_cell.sv]
// One ring slot with its stage of the front and rear gather chain.
`timescale 1ns / 1ps

module cdq_cell #(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  cdq_pkg::t_slot_wr i_wr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [AW-1:0]    i_front_ptr,
    input  logic [AW-1:0]    i_rear_ptr,
    input  cdq_pkg::t_pair   i_prev,
    output cdq_pkg::t_pair   o_gather
);

    logic [cdq_pkg::WORD_W-1:0] r_word;
    cdq_pkg::t_pair             r_gather;

    always_ff @(posedge i_clk) begin
        if (i_wr.we && (i_wr_addr == AW'(IDX))) begin
            r_word <= i_wr.data;
        end
    end

    // Each stage takes its own word where a pointer names it, else the
    // word handed on from the previous stage.
    always_ff @(posedge i_clk) begin
        r_gather.front <= (i_front_ptr == AW'(IDX)) ? r_word : i_prev.front;
        r_gather.rear  <= (i_rear_ptr == AW'(IDX)) ? r_word : i_prev.rear;
    end

    assign o_gather = r_gather;

endmodule

[tb/sv/circular_deque_checker.sv]
// Checker for the circular deque core: tracks the deque state and compares every status word.
`timescale 1ns / 1ps

module circular_deque_checker #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [2:0]                 i_cmd,
    input  logic [cdq_pkg::WORD_W-1:0] i_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_ok,
    input  logic [cdq_pkg::WORD_W-1:0] i_front,
    input  logic [cdq_pkg::WORD_W-1:0] i_rear,
    input  logic                       i_empty,
    input  logic                       i_full,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]  i_cfg_data,
    output int                         o_pending,
    output int                         o_fail_count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic                       ok;
        logic [cdq_pkg::WORD_W-1:0] front;
        logic [cdq_pkg::WORD_W-1:0] rear;
        logic                       empty;
        logic                       full;
    } t_deque_view;

    logic [cdq_pkg::WORD_W-1:0] slots [DEPTH] = '{default: '0};
    logic [IDX_W-1:0]           head_idx = '0;
    logic [IDX_W-1:0]           tail_idx = '0;
    int                         held = 0;
    logic [cdq_pkg::CAP_W-1:0]  cap_reg = cdq_pkg::CAP_RESET;
    t_deque_view                status_due [$];
    int                         fails = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] idx, input int span);
        return (int'(idx) + 1 >= span) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] idx, input int span);
        return (idx == '0) ? IDX_W'(span - 1) : idx - 1'b1;
    endfunction

    function automatic t_deque_view apply_command(input logic [2:0] cmd,
                                                  input logic [cdq_pkg::WORD_W-1:0] value);
        int          span;
        logic        was_full;
        logic        was_empty;
        t_deque_view st;
        span = (cap_reg == '0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
        was_full = (held >= span);
        was_empty = (held == 0);
        st.ok = 1'b0;
        case (cmd)
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
                if (!was_full) begin
                    if (was_empty) begin
                        head_idx = '0;
                        tail_idx = '0;
                        slots[0] = value;
                    end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
                        head_idx = idx_down(head_idx, span);
                        slots[head_idx] = value;
                    end else begin
                        tail_idx = idx_up(tail_idx, span);
                        slots[tail_idx] = value;
                    end
                    held++;
                    st.ok = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
                if (!was_empty) begin
                    if (cmd == cdq_pkg::CMD_POP_FRONT) begin
                        head_idx = idx_up(head_idx, span);
                    end else begin
                        tail_idx = idx_down(tail_idx, span);
                    end
                    held--;
                    st.ok = 1'b1;
                end
            end
            cdq_pkg::CMD_NOP: begin
                st.ok = 1'b1;
            end
            default: begin
            end
        endcase
        st.empty = (held == 0);
        st.full  = (held >= span);
        st.front = st.empty ? cdq_pkg::EMPTY_WORD : slots[head_idx];
        st.rear  = st.empty ? cdq_pkg::EMPTY_WORD : slots[tail_idx];
        return st;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [cdq_pkg::WORD_W-1:0] want,
                                        input logic [cdq_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            fails++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_deque_view want;
        if (!i_rst_n) begin
            head_idx = '0;
            tail_idx = '0;
            held     = 0;
            cap_reg  = cdq_pkg::CAP_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                cap_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    fails++;
                    $error("Status word arrived with no command outstanding.");
                end else begin
                    want = status_due.pop_front();
                    check_field("ok", cdq_pkg::WORD_W'(want.ok), cdq_pkg::WORD_W'(i_ok));
                    check_field("front_value", want.front, i_front);
                    check_field("rear_value", want.rear, i_rear);
                    check_field("is_empty", cdq_pkg::WORD_W'(want.empty),
                                cdq_pkg::WORD_W'(i_empty));
                    check_field("is_full", cdq_pkg::WORD_W'(want.full),
                                cdq_pkg::WORD_W'(i_full));
                end
            end
            if (i_in_valid && i_in_ready) begin
                status_due.push_back(apply_command(i_cmd, i_value));
            end
        end
        o_pending    <= status_due.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_circular_deque_core.sv]
// Testbench top for the circular deque core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_circular_deque_core;

    localparam int DEPTH = 64;

    localparam logic [2:0] CMD_UNDEF_5 = 3'd5;
    localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [2:0] CMD_UNDEF_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    logic [2:0]                 cmd_code = cdq_pkg::CMD_NOP;
    logic [cdq_pkg::WORD_W-1:0] cmd_value = '0;

    logic                       stat_valid;
    logic                       stat_ready = 1'b0;
    logic                       stat_ok;
    logic [cdq_pkg::WORD_W-1:0] stat_front;
    logic [cdq_pkg::WORD_W-1:0] stat_rear;
    logic                       stat_empty;
    logic                       stat_full;

    logic                       cap_valid = 1'b0;
    logic                       cap_ready;
    logic [cdq_pkg::CAP_W-1:0]  cap_data = cdq_pkg::CAP_RESET;

    int pending;
    int fail_count;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int ring_span = DEPTH;

    always #5 clk = ~clk;

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (cmd_valid),
        .o_in_ready   (cmd_ready),
        .i_cmd        (cmd_code),
        .i_value      (cmd_value),
        .o_out_valid  (stat_valid),
        .i_out_ready  (stat_ready),
        .o_ok         (stat_ok),
        .o_front_value(stat_front),
        .o_rear_value (stat_rear),
        .o_is_empty   (stat_empty),
        .o_is_full    (stat_full),
        .i_cfg_valid  (cap_valid),
        .o_cfg_ready  (cap_ready),
        .i_cfg_data   (cap_data)
    );

    circular_deque_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .i_in_ready  (cmd_ready),
        .i_cmd       (cmd_code),
        .i_value     (cmd_value),
        .i_out_valid (stat_valid),
        .i_out_ready (stat_ready),
        .i_ok        (stat_ok),
        .i_front     (stat_front),
        .i_rear      (stat_rear),
        .i_empty     (stat_empty),
        .i_full      (stat_full),
        .i_cfg_valid (cap_valid),
        .i_cfg_ready (cap_ready),
        .i_cfg_data  (cap_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always @(posedge clk) begin
        stat_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [cdq_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input logic [2:0] c, input logic [cdq_pkg::WORD_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_code  <= c;
        cmd_value <= v;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] d);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        cap_valid <= 1'b1;
        cap_data  <= d;
        @(posedge clk);
        while (!cap_ready) @(posedge clk);
        cap_valid <= 1'b0;
        ring_span = (d == '0) ? 1 : ((int'(d) > DEPTH) ? DEPTH : int'(d));
    endtask

    task automatic run_random(input int n_items);
        int         issued;
        int         kind;
        int         burst;
        int         i;
        logic [2:0] c;
        issued = 0;
        while (issued < n_items) begin
            kind = $urandom_range(0, 9);
            burst = $urandom_range(1, ring_span + 2);
            for (i = 0; i < burst; i++) begin
                if (kind < 4) begin
                    c = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT;
                end else if (kind < 8) begin
                    c = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_REAR : cdq_pkg::CMD_POP_FRONT;
                end else begin
                    c = 3'($urandom);
                end
                send_command(c, random_word());
            end
            issued += burst;
        end
    endtask

    initial begin
        int                        phase;
        int                        i;
        logic [cdq_pkg::CAP_W-1:0] cap_pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(cdq_pkg::CMD_POP_FRONT, random_word());
        send_command(cdq_pkg::CMD_POP_REAR, random_word());
        send_command(cdq_pkg::CMD_NOP, random_word());
        send_command(CMD_UNDEF_5, random_word());
        send_command(CMD_UNDEF_6, random_word());
        send_command(CMD_UNDEF_7, random_word());
        send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(cdq_pkg::CMD_PUSH_REAR, 32'h7FFF_FFFF);
        send_command(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_command(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
        send_command(cdq_pkg::CMD_POP_FRONT, random_word());
        send_command(cdq_pkg::CMD_POP_REAR, random_word());
        send_command(cdq_pkg::CMD_POP_REAR, random_word());
        send_command(cdq_pkg::CMD_POP_FRONT, random_word());
        send_command(cdq_pkg::CMD_POP_FRONT, random_word());

        write_capacity(7'd0);
        send_command(cdq_pkg::CMD_PUSH_REAR, 32'h5555_5555);
        send_command(cdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        send_command(cdq_pkg::CMD_POP_FRONT, random_word());
        send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
        send_command(cdq_pkg::CMD_POP_REAR, random_word());

        write_capacity(7'd127);
        send_command(cdq_pkg::CMD_PUSH_REAR, random_word());
        send_command(cdq_pkg::CMD_PUSH_FRONT, random_word());
        send_command(cdq_pkg::CMD_POP_REAR, random_word());
        send_command(cdq_pkg::CMD_POP_FRONT, random_word());

        // Fill every slot once so later capacity changes can never expose an unwritten slot.
        write_capacity(cdq_pkg::CAP_RESET);
        for (i = 0; i < DEPTH; i++) begin
            send_command(cdq_pkg::CMD_PUSH_REAR, random_word());
        end
        send_command(cdq_pkg::CMD_PUSH_FRONT, random_word());

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: cap_pick = 7'd2;
                1: cap_pick = cdq_pkg::CAP_RESET;
                2: cap_pick = 7'($urandom_range(3, 63));
                3: cap_pick = 7'd1;
                4: cap_pick = 7'($urandom_range(65, 126));
                default: cap_pick = 7'($urandom_range(2, 12));
            endcase
            write_capacity(cap_pick);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 46;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 46;
                end
                default: begin
                    send_idle_pct = 34;
                    stall_pct = 34;
                end
            endcase
            run_random(60);
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cdq_pkg.sv
rtl/core/cdq_cell.sv
rtl/core/circular_deque_core.sv
tb/sv/circular_deque_checker.sv
tb/sv/tb_circular_deque_core.sv
